### sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on nothing; the user supplies clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/egcd_pkg.sv
// Shared types and constants for the extended gcd / modular inverse block.
// Used by the controller, the datapath, the top level and the checker.
package egcd_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FIELD_W        = 32;

  typedef enum logic {
    REQ_EXT_GCD = 1'b0,
    REQ_INVERSE = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic                      req_type;
    logic signed [FIELD_W-1:0] value_a;
    logic signed [FIELD_W-1:0] value_b;
  } req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] gcd_value;
    logic signed [FIELD_W-1:0] coef_a;
    logic signed [FIELD_W-1:0] coef_b;
    logic                      is_unit;
    logic                      status;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_ITER,
    OP_FIX_A,
    OP_FIX_U,
    OP_RESULT
  } dp_op_t;

  typedef enum logic [1:0] {
    SEL_ITER,
    SEL_A,
    SEL_U
  } div_sel_t;

  typedef struct packed {
    dp_op_t   op;
    div_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic mode;
    logic r_neg;
    logic rp_zero;
    logic u_neg;
  } dp_stat_t;

endpackage

### sv/egcd_ctrl.sv
// Sequencer for the extended gcd block: drives datapath commands.
// Depends on egcd_pkg for the command and status types.
module egcd_ctrl #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  egcd_pkg::dp_stat_t stat,
  output egcd_pkg::dp_cmd_t  cmd
);

  localparam int CW = $clog2(DATA_WIDTH);
  localparam logic [CW-1:0] LAST_BIT = CW'(DATA_WIDTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOOP,
    S_DIV,
    S_UPDATE,
    S_FIX_A,
    S_FIX_U,
    S_DONE
  } state_t;

  state_t             state;
  logic [CW-1:0]      cnt;
  egcd_pkg::div_sel_t div_sel;

  always_comb begin
    cmd.op  = egcd_pkg::OP_NONE;
    cmd.sel = egcd_pkg::SEL_ITER;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = egcd_pkg::OP_LOAD;
        end
      end
      S_CHECK: begin
        if (!stat.err && stat.mode && stat.r_neg) begin
          cmd.op  = egcd_pkg::OP_DIV_START;
          cmd.sel = egcd_pkg::SEL_A;
        end
      end
      S_LOOP: begin
        if (!stat.rp_zero) begin
          cmd.op  = egcd_pkg::OP_DIV_START;
          cmd.sel = egcd_pkg::SEL_ITER;
        end else if (stat.mode && stat.u_neg) begin
          cmd.op  = egcd_pkg::OP_DIV_START;
          cmd.sel = egcd_pkg::SEL_U;
        end
      end
      S_DIV:    cmd.op = egcd_pkg::OP_DIV_STEP;
      S_UPDATE: cmd.op = egcd_pkg::OP_ITER;
      S_FIX_A:  cmd.op = egcd_pkg::OP_FIX_A;
      S_FIX_U:  cmd.op = egcd_pkg::OP_FIX_U;
      S_DONE:   cmd.op = egcd_pkg::OP_RESULT;
      default:  cmd.op = egcd_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      busy    <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
      div_sel <= egcd_pkg::SEL_ITER;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CHECK;
            busy  <= 1'b1;
          end
        end
        S_CHECK: begin
          if (stat.err) begin
            state <= S_DONE;
          end else if (stat.mode && stat.r_neg) begin
            state   <= S_DIV;
            div_sel <= egcd_pkg::SEL_A;
            cnt     <= '0;
          end else begin
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (!stat.rp_zero) begin
            state   <= S_DIV;
            div_sel <= egcd_pkg::SEL_ITER;
            cnt     <= '0;
          end else if (stat.mode && stat.u_neg) begin
            state   <= S_DIV;
            div_sel <= egcd_pkg::SEL_U;
            cnt     <= '0;
          end else begin
            state <= S_DONE;
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_BIT) begin
            case (div_sel)
              egcd_pkg::SEL_A: state <= S_FIX_A;
              egcd_pkg::SEL_U: state <= S_FIX_U;
              default:         state <= S_UPDATE;
            endcase
          end
        end
        S_UPDATE: state <= S_LOOP;
        S_FIX_A:  state <= S_LOOP;
        S_FIX_U:  state <= S_DONE;
        S_DONE: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/egcd_datapath.sv
// Datapath of the extended gcd block: Euclid registers, a restoring divider
// that also forms the coefficient products, and the result register.
// Depends on egcd_pkg.
module egcd_datapath #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  egcd_pkg::req_t     req,
  input  egcd_pkg::dp_cmd_t  cmd,
  output egcd_pkg::dp_stat_t stat,
  output egcd_pkg::rsp_t     rsp
);

  localparam int DW = DATA_WIDTH;
  localparam int FW = egcd_pkg::FIELD_W;

  logic [DW-1:0] r, rp, u, up, v, vp, m;
  logic          mode, err;

  // Divider state: quotient shifts in from the right, products by Horner rule.
  logic [DW-1:0] quo, rem, dmag, pu, pv;
  logic          qneg, rneg;

  logic [DW-1:0] x, y, x_mag, y_mag;
  logic [DW-1:0] a_in, b_in;
  logic [DW-1:0] rem_sh, rs;
  logic [DW:0]   diff;
  logic          qbit;

  assign a_in = DW'(req.value_a);
  assign b_in = DW'(req.value_b);

  always_comb begin
    case (cmd.sel)
      egcd_pkg::SEL_A: begin
        x = r;
        y = m;
      end
      egcd_pkg::SEL_U: begin
        x = u;
        y = m;
      end
      default: begin
        x = r;
        y = rp;
      end
    endcase
  end

  assign x_mag  = x[DW-1] ? (~x + 1'b1) : x;
  assign y_mag  = y[DW-1] ? (~y + 1'b1) : y;
  // The partial remainder stays below the divisor magnitude, so its top bit is clear.
  assign rem_sh = {rem[DW-2:0], quo[DW-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, dmag};
  assign qbit   = ~diff[DW];
  assign rs     = rneg ? (~rem + 1'b1) : rem;

  always_ff @(posedge clk) begin
    case (cmd.op)
      egcd_pkg::OP_LOAD: begin
        r    <= a_in;
        rp   <= b_in;
        u    <= DW'(1);
        up   <= '0;
        v    <= '0;
        vp   <= DW'(1);
        m    <= b_in;
        mode <= req.req_type;
        err  <= (req.req_type == egcd_pkg::REQ_INVERSE) && ((b_in == '0) || b_in[DW-1]);
      end
      egcd_pkg::OP_DIV_START: begin
        quo  <= x_mag;
        rem  <= '0;
        dmag <= y_mag;
        pu   <= '0;
        pv   <= '0;
        qneg <= x[DW-1] ^ y[DW-1];
        rneg <= x[DW-1];
      end
      egcd_pkg::OP_DIV_STEP: begin
        rem <= qbit ? diff[DW-1:0] : rem_sh;
        quo <= {quo[DW-2:0], qbit};
        pu  <= {pu[DW-2:0], 1'b0} + (qbit ? up : '0);
        pv  <= {pv[DW-2:0], 1'b0} + (qbit ? vp : '0);
      end
      egcd_pkg::OP_ITER: begin
        r  <= rp;
        rp <= rs;
        u  <= up;
        v  <= vp;
        // A negative quotient turns the subtraction of the product into an add.
        up <= qneg ? (u + pu) : (u - pu);
        vp <= qneg ? (v + pv) : (v - pv);
      end
      egcd_pkg::OP_FIX_A: r <= rs + m;
      egcd_pkg::OP_FIX_U: u <= rs + m;
      egcd_pkg::OP_RESULT: begin
        rsp.gcd_value <= err ? '0 : FW'($signed(r));
        rsp.coef_a    <= err ? '0 : FW'($signed(u));
        rsp.coef_b    <= err ? '0 : FW'($signed(v));
        rsp.is_unit   <= !err && (r == DW'(1));
        rsp.status    <= err;
      end
      default: begin
      end
    endcase
  end

  assign stat.err     = err;
  assign stat.mode    = mode;
  assign stat.r_neg   = r[DW-1];
  assign stat.rp_zero = (rp == '0);
  assign stat.u_neg   = u[DW-1];

endmodule

### sv/extended_gcd_modular_inverse.sv
// Extended gcd and modular inverse of signed operands. An item is taken when
// start is high and busy is low; busy then stays high until the result shows.
// The result is marked by done, high for a single cycle, and cannot be held
// off; rsp then holds it until the next result. Each Euclid step runs a
// restoring divider that yields one quotient bit per cycle and builds both
// coefficient products in the same pass, then updates the Euclid registers.
// There are at most about 46 Euclid steps for 32-bit operands; inverse mode
// adds up to two more divisions, and a bad modulus ends the item without any
// division.
module extended_gcd_modular_inverse #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  egcd_pkg::req_t req,
  output logic           done,
  output egcd_pkg::rsp_t rsp
);

  egcd_pkg::dp_cmd_t  cmd;
  egcd_pkg::dp_stat_t stat;

  egcd_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .stat (stat),
    .cmd  (cmd)
  );

  egcd_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk (clk),
    .req (req),
    .cmd (cmd),
    .stat(stat),
    .rsp (rsp)
  );

endmodule

### sv/egcd_checker.sv
// Port-level checks for the extended gcd block, bound to its top level.
// Depends on egcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module egcd_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input egcd_pkg::rsp_t rsp
);

  logic rsp_clear;
  logic unit_ok;

  assign rsp_clear = (rsp.gcd_value == '0) && (rsp.coef_a == '0) && (rsp.coef_b == '0) &&
                     !rsp.is_unit;
  assign unit_ok   = (rsp.gcd_value == 32'sd1) && !rsp.status;

  `ASSERT_ALWAYS(a_reset_quiet, rst |=> (!busy && !done), "busy or done after reset")
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> (busy && !done), "item accepted but not busy")
  `ASSERT_CLK(a_done_free, done |-> !busy, "result shown while still busy")
  `ASSERT_CLK(a_err_zero, (done && rsp.status) |-> rsp_clear, "error result carries data")
  `ASSERT_CLK(a_unit_one, (done && rsp.is_unit) |-> unit_ok, "unit flag without gcd of one")

endmodule

bind extended_gcd_modular_inverse egcd_checker u_egcd_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);

### test/extended_gcd_modular_inverse_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for extended_gcd_modular_inverse: extended gcd and
// modular inverse items with random gaps, checked against an in-bench predictor.
// Depends on egcd_pkg and the extended_gcd_modular_inverse top level.
module extended_gcd_modular_inverse_tb;

  localparam logic [31:0] MIN_VAL     = 32'h8000_0000;
  localparam logic [31:0] MAX_VAL     = 32'h7fff_ffff;
  localparam int          STEP_CAP    = 256;
  localparam int          QUIET_LIMIT = 20000;
  localparam int          SETTLE_CYCLES = 2000;
  localparam int          RANDOM_ITEMS  = 370;

  typedef struct {
    egcd_pkg::req_t item;
    int unsigned    gap;
    bit             drain_first;
  } pending_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  egcd_pkg::req_t req = '0;
  logic busy;
  logic done;
  egcd_pkg::rsp_t rsp;

  pending_t       pending_items[$];
  egcd_pkg::rsp_t expected_rsp[$];
  int unsigned gap_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned error_count = 0;

  extended_gcd_modular_inverse DUT (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Signed division rounds toward zero; magnitudes are divided unsigned, so the
  // most negative value over minus one wraps back to itself.
  function automatic logic [31:0] trunc_quot(logic [31:0] x, logic [31:0] y);
    logic [31:0] mx, my, qm;
    mx = x[31] ? -x : x;
    my = y[31] ? -y : y;
    qm = mx / my;
    return (x[31] ^ y[31]) ? -qm : qm;
  endfunction

  function automatic logic [31:0] trunc_rem(logic [31:0] x, logic [31:0] y);
    logic [31:0] mx, my, rm;
    mx = x[31] ? -x : x;
    my = y[31] ? -y : y;
    rm = mx % my;
    return x[31] ? -rm : rm;
  endfunction

  function automatic void euclid(input logic [31:0] a, input logic [31:0] b,
                                 output logic [31:0] g, output logic [31:0] u,
                                 output logic [31:0] v);
    logic [31:0] r, rp, up, vp, q, nr, nu, nv;
    int n;
    r = a; rp = b;
    u = 32'd1; up = '0;
    v = '0;    vp = 32'd1;
    n = 0;
    while (rp != 0 && n < STEP_CAP) begin
      q  = trunc_quot(r, rp);
      nr = r - rp * q;
      nu = u - up * q;
      nv = v - vp * q;
      r = rp; u = up; v = vp;
      rp = nr; up = nu; vp = nv;
      n++;
    end
    g = r;
  endfunction

  function automatic egcd_pkg::rsp_t predict_gcd(egcd_pkg::req_t r);
    logic [31:0] a, b, g, u, v;
    egcd_pkg::rsp_t o;
    a = r.value_a;
    b = r.value_b;
    g = '0; u = '0; v = '0;
    o = '0;
    if (r.req_type == egcd_pkg::REQ_EXT_GCD) begin
      euclid(a, b, g, u, v);
    end else if (b == 0 || b[31]) begin
      o.status = 1'b1;
    end else begin
      // A negative multiple of the modulus maps to the modulus itself, not 0.
      if (a[31]) a = trunc_rem(a, b) + b;
      euclid(a, b, g, u, v);
      if (u[31]) u = trunc_rem(u, b) + b;
    end
    o.gcd_value = g;
    o.coef_a    = u;
    o.coef_b    = v;
    o.is_unit   = !o.status && g == 32'd1;
    return o;
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] x;
    x = $urandom();
    case ($urandom_range(0, 7))
      0, 1, 2: return x;
      3:       return $urandom_range(0, 100) - 50;
      4:       return {{16{x[15]}}, x[15:0]};
      5: begin
        case ($urandom_range(0, 4))
          0:       return MIN_VAL;
          1:       return MAX_VAL;
          2:       return 32'hffff_ffff;
          3:       return '0;
          default: return 32'd1;
        endcase
      end
      6: begin
        x = 32'd1 << $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -x : x;
      end
      default: return x >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic add_item(egcd_pkg::req_kind_t kind, logic [31:0] a, logic [31:0] b,
                          int unsigned gap, bit drain_first);
    pending_t p;
    p.item.req_type = kind;
    p.item.value_a  = a;
    p.item.value_b  = b;
    p.gap           = gap;
    p.drain_first   = drain_first;
    pending_items.push_back(p);
  endtask

  // Driver: an item stays on req with start high until busy is low at an edge.
  always @(posedge clk) begin
    logic start_n;
    if (rst) begin
      start     <= 1'b0;
      req       <= '0;
      gap_count = 0;
    end else begin
      start_n = start;
      if (start && !busy) begin
        expected_rsp.push_back(predict_gcd(req));
        start_n = 1'b0;
      end
      if (!start_n && pending_items.size() != 0) begin
        if (pending_items[0].drain_first && expected_rsp.size() != 0) begin
          gap_count = 0;
        end else if (gap_count < pending_items[0].gap) begin
          gap_count++;
        end else begin
          req       <= pending_items[0].item;
          start_n   = 1'b1;
          gap_count = 0;
          void'(pending_items.pop_front());
        end
      end
      start <= start_n;
    end
  end

  // Monitor: a result is valid only during the single cycle that done is high.
  always @(posedge clk) begin
    egcd_pkg::rsp_t want;
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        error_count++;
        $display("Unexpected result: gcd=%0d coef_a=%0d coef_b=%0d unit=%0b status=%0b",
                 rsp.gcd_value, rsp.coef_a, rsp.coef_b, rsp.is_unit, rsp.status);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.gcd_value !== want.gcd_value || rsp.coef_a !== want.coef_a ||
            rsp.coef_b !== want.coef_b || rsp.is_unit !== want.is_unit ||
            rsp.status !== want.status) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected gcd=%0d coef_a=%0d coef_b=%0d unit=%0b status=%0b",
                     want.gcd_value, want.coef_a, want.coef_b, want.is_unit, want.status);
            $display("          actual   gcd=%0d coef_a=%0d coef_b=%0d unit=%0b status=%0b",
                     rsp.gcd_value, rsp.coef_a, rsp.coef_b, rsp.is_unit, rsp.status);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither an item nor a result is accepted.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] a, b;
    int unsigned gap;
    egcd_pkg::req_kind_t kind;

    // Zero divisor, zero dividend, wrapping division and overflow of coefficients.
    add_item(egcd_pkg::REQ_EXT_GCD, '0, '0, 0, 1'b0);
    add_item(egcd_pkg::REQ_EXT_GCD, 32'd5, '0, 0, 1'b0);
    add_item(egcd_pkg::REQ_EXT_GCD, 32'd1, '0, 3, 1'b0);
    add_item(egcd_pkg::REQ_EXT_GCD, '0, 32'd7, 0, 1'b0);
    add_item(egcd_pkg::REQ_EXT_GCD, MIN_VAL, 32'hffff_ffff, 1, 1'b0);
    add_item(egcd_pkg::REQ_EXT_GCD, MIN_VAL, MIN_VAL, 0, 1'b0);
    add_item(egcd_pkg::REQ_EXT_GCD, MAX_VAL, MAX_VAL, 7, 1'b0);
    add_item(egcd_pkg::REQ_EXT_GCD, MAX_VAL, MIN_VAL, 0, 1'b0);
    add_item(egcd_pkg::REQ_EXT_GCD, MIN_VAL, MAX_VAL, 2, 1'b0);
    add_item(egcd_pkg::REQ_EXT_GCD, -32'sd12, 32'd18, 0, 1'b0);
    add_item(egcd_pkg::REQ_EXT_GCD, 32'd240, -32'sd46, 14, 1'b0);
    add_item(egcd_pkg::REQ_EXT_GCD, 32'hffff_ffff, 32'hffff_ffff, 0, 1'b0);
    // Adjacent Fibonacci numbers give the longest Euclid chain.
    add_item(egcd_pkg::REQ_EXT_GCD, 32'd1836311903, 32'd1134903170, 0, 1'b0);
    // Nonpositive modulus.
    add_item(egcd_pkg::REQ_INVERSE, 32'd3, '0, 0, 1'b0);
    add_item(egcd_pkg::REQ_INVERSE, 32'd3, -32'sd5, 5, 1'b0);
    add_item(egcd_pkg::REQ_INVERSE, MAX_VAL, MIN_VAL, 0, 1'b0);
    // Regular inverses, a negative multiple of the modulus and no inverse.
    add_item(egcd_pkg::REQ_INVERSE, 32'd3, 32'd7, 0, 1'b0);
    add_item(egcd_pkg::REQ_INVERSE, -32'sd3, 32'd7, 0, 1'b0);
    add_item(egcd_pkg::REQ_INVERSE, -32'sd14, 32'd7, 9, 1'b0);
    add_item(egcd_pkg::REQ_INVERSE, 32'd4, 32'd8, 0, 1'b0);
    add_item(egcd_pkg::REQ_INVERSE, MIN_VAL, MAX_VAL, 0, 1'b0);
    add_item(egcd_pkg::REQ_INVERSE, 32'd1, 32'd1, 0, 1'b0);
    add_item(egcd_pkg::REQ_INVERSE, '0, 32'd5, 4, 1'b0);
    add_item(egcd_pkg::REQ_INVERSE, 32'hffff_ffff, MAX_VAL, 0, 1'b0);
    add_item(egcd_pkg::REQ_INVERSE, 32'd1134903170, 32'd1836311903, 0, 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 1) ? egcd_pkg::REQ_INVERSE : egcd_pkg::REQ_EXT_GCD;
      a = pick_operand();
      b = pick_operand();
      // Most inverse items carry a usable modulus so the loop runs in full.
      if (kind == egcd_pkg::REQ_INVERSE && $urandom_range(0, 9) < 8) begin
        b[31] = 1'b0;
        if (b == 0) b = $urandom_range(1, 1000);
      end
      if (i >= 120 && i < 170) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = 0;
      else gap = $urandom_range(0, 14);
      add_item(kind, a, b, gap, i == 0 || i == 200);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || start || expected_rsp.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_rsp.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
